>>> rtl/jpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpt_pkg
// Shared types and constants for the JSONPath expression tokenizer.
// ----------------------------------------------------------------------------
package jpt_pkg;

  localparam int INDEX_BITS = 32;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] CH_DOLLAR  = 16'h0024;
  localparam logic [15:0] CH_DOT     = 16'h002E;
  localparam logic [15:0] CH_LBRACK  = 16'h005B;
  localparam logic [15:0] CH_RBRACK  = 16'h005D;
  localparam logic [15:0] CH_STAR    = 16'h002A;
  localparam logic [15:0] CH_SQUOTE  = 16'h0027;
  localparam logic [15:0] CH_DQUOTE  = 16'h0022;
  localparam logic [15:0] CH_ZERO    = 16'h0030;
  localparam logic [15:0] CH_NINE    = 16'h0039;

  localparam logic [2:0] KIND_KEY_UNIT = 3'd0;
  localparam logic [2:0] KIND_KEY_END  = 3'd1;
  localparam logic [2:0] KIND_INDEX    = 3'd2;
  localparam logic [2:0] KIND_WILDCARD = 3'd3;
  localparam logic [2:0] KIND_ACCEPT   = 3'd4;
  localparam logic [2:0] KIND_REJECT   = 3'd5;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_expression;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] key_unit;
    logic [31:0] index_value;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage
`default_nettype wire

>>> rtl/jpt_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpt_parser
// Parse state machine: one code unit per accepted transaction, up to two
// results handed to the result queue in the same cycle.
// ----------------------------------------------------------------------------
module jpt_parser
  import jpt_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   accept,
  input  item_t item,
  output push_t push
);

  typedef enum logic [8:0] {
    MODE_DOLLAR     = 9'b000000001,
    MODE_BETWEEN    = 9'b000000010,
    MODE_DOTKEY     = 9'b000000100,
    MODE_BRACKET    = 9'b000001000,
    MODE_WILDCLOSE  = 9'b000010000,
    MODE_QUOTED     = 9'b000100000,
    MODE_QUOTECLOSE = 9'b001000000,
    MODE_DIGITS     = 9'b010000000,
    MODE_REJECTED   = 9'b100000000
  } mode_t;

  localparam int PROD_BITS = INDEX_BITS + 4;

  mode_t                  mode, mode_next, mode_step;
  logic                   key_started, key_started_next, key_step;
  logic                   quote_is_double, quote_is_double_next, quote_step;
  logic [INDEX_BITS-1:0]  acc, acc_next, acc_step;

  logic [15:0]            c;
  logic                   is_digit, is_quote, go_reject;
  logic [3:0]             digit;
  logic [PROD_BITS-1:0]   prod;
  logic                   overflow;
  logic                   emit;
  result_t                e_res, v_res;
  logic                   verdict_ok;

  assign c        = item.code_unit;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_quote = (c == CH_SQUOTE) || (c == CH_DQUOTE);
  assign digit    = c[3:0];
  assign prod     = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + PROD_BITS'(digit);
  assign overflow = |prod[PROD_BITS-1:INDEX_BITS];

  always_comb begin
    mode_step  = mode;
    key_step   = key_started;
    quote_step = quote_is_double;
    acc_step   = acc;
    go_reject  = 1'b0;
    emit       = 1'b0;
    e_res      = '0;
    unique case (mode)
      MODE_DOLLAR: begin
        if (c == CH_DOLLAR) mode_step = MODE_BETWEEN;
        else go_reject = 1'b1;
      end
      MODE_BETWEEN: begin
        if (c == CH_DOT) begin
          mode_step = MODE_DOTKEY;
          key_step  = 1'b0;
        end else if (c == CH_LBRACK) begin
          mode_step = MODE_BRACKET;
        end else begin
          go_reject = 1'b1;
        end
      end
      MODE_DOTKEY: begin
        if (c != CH_DOT && c != CH_LBRACK && c != CH_RBRACK && !is_quote) begin
          emit              = 1'b1;
          e_res.result_kind = KIND_KEY_UNIT;
          e_res.key_unit    = c;
          key_step          = 1'b1;
        end else if (!key_started || c == CH_RBRACK || is_quote) begin
          go_reject = 1'b1;
        end else begin
          emit              = 1'b1;
          e_res.result_kind = KIND_KEY_END;
          key_step          = 1'b0;
          if (c == CH_LBRACK) mode_step = MODE_BRACKET;
        end
      end
      MODE_BRACKET: begin
        if (c == CH_STAR) begin
          mode_step = MODE_WILDCLOSE;
        end else if (is_quote) begin
          mode_step  = MODE_QUOTED;
          quote_step = (c == CH_DQUOTE);
        end else if (is_digit) begin
          mode_step = MODE_DIGITS;
          acc_step  = INDEX_BITS'(digit);
        end else begin
          go_reject = 1'b1;
        end
      end
      MODE_WILDCLOSE: begin
        if (c == CH_RBRACK) begin
          emit              = 1'b1;
          e_res.result_kind = KIND_WILDCARD;
          mode_step         = MODE_BETWEEN;
        end else begin
          go_reject = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (c == (quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
          mode_step = MODE_QUOTECLOSE;
        end else begin
          emit              = 1'b1;
          e_res.result_kind = KIND_KEY_UNIT;
          e_res.key_unit    = c;
        end
      end
      MODE_QUOTECLOSE: begin
        if (c == CH_RBRACK) begin
          emit              = 1'b1;
          e_res.result_kind = KIND_KEY_END;
          mode_step         = MODE_BETWEEN;
        end else begin
          go_reject = 1'b1;
        end
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          if (overflow) go_reject = 1'b1;
          else acc_step = prod[INDEX_BITS-1:0];
        end else if (c == CH_RBRACK) begin
          emit              = 1'b1;
          e_res.result_kind = KIND_INDEX;
          e_res.index_value = 32'(acc);
          acc_step          = '0;
          mode_step         = MODE_BETWEEN;
        end else begin
          go_reject = 1'b1;
        end
      end
      MODE_REJECTED: begin
        mode_step = MODE_REJECTED;
      end
      default: begin
        mode_step = MODE_REJECTED;
      end
    endcase
    if (go_reject) begin
      mode_step = MODE_REJECTED;
      acc_step  = '0;
      key_step  = 1'b0;
    end
  end

  assign verdict_ok = (mode_step == MODE_BETWEEN) || (mode_step == MODE_DOTKEY && key_step);

  always_comb begin
    v_res             = '0;
    v_res.result_kind = verdict_ok ? KIND_ACCEPT : KIND_REJECT;
    v_res.last_of_run = 1'b1;
    push              = '0;
    mode_next            = mode;
    key_started_next     = key_started;
    quote_is_double_next = quote_is_double;
    acc_next             = acc;
    if (accept) begin
      if (item.end_of_expression) begin
        mode_next            = MODE_DOLLAR;
        key_started_next     = 1'b0;
        quote_is_double_next = 1'b0;
        acc_next             = '0;
        if (emit) begin
          push.count  = 2'd2;
          push.first  = e_res;
          push.second = v_res;
        end else begin
          push.count = 2'd1;
          push.first = v_res;
        end
      end else begin
        mode_next            = mode_step;
        key_started_next     = key_step;
        quote_is_double_next = quote_step;
        acc_next             = acc_step;
        if (emit) begin
          push.count             = 2'd1;
          push.first             = e_res;
          push.first.last_of_run = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_DOLLAR;
      key_started     <= 1'b0;
      quote_is_double <= 1'b0;
      acc             <= '0;
    end else begin
      mode            <= mode_next;
      key_started     <= key_started_next;
      quote_is_double <= quote_is_double_next;
      acc             <= acc_next;
    end
  end

`ifndef SYNTHESIS
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && item.end_of_expression |=> mode == MODE_DOLLAR && acc == '0)
    else $error("end of expression did not return parser to start");
  a_key_in_dotkey: assert property (@(posedge clk) disable iff (rst)
    key_started |-> mode == MODE_DOTKEY)
    else $error("key_started outside dot key");
  a_acc_in_digits: assert property (@(posedge clk) disable iff (rst)
    acc != '0 |-> mode == MODE_DIGITS)
    else $error("index accumulator live outside digits");
`endif

endmodule
`default_nettype wire

>>> rtl/jpt_result_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpt_result_queue
// Small result queue: takes up to two results per cycle, delivers one per
// output transaction.
// ----------------------------------------------------------------------------
module jpt_result_queue
  import jpt_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  push_t   push,
  output logic    space,
  output logic    result_valid,
  input  wire     result_ready,
  output result_t result
);

  result_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr, rd;
  logic [QUEUE_PTR_BITS:0]   count, count_next;
  logic                      pop;

  assign result_valid = (count != '0);
  assign result       = entries[rd];
  assign pop          = result_valid && result_ready;
  assign space        = (count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));
  assign count_next   = count + (QUEUE_PTR_BITS+1)'(push.count)
                        - (QUEUE_PTR_BITS+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr] <= push.first;
    if (push.count == 2'd2) entries[wr + QUEUE_PTR_BITS'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + QUEUE_PTR_BITS'(push.count);
      if (pop) rd <= rd + QUEUE_PTR_BITS'(1);
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count + (QUEUE_PTR_BITS+1)'(push.count)
      <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    QUEUE_PTR_BITS'(wr - rd) == count[QUEUE_PTR_BITS-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

>>> rtl/json_path_tokenizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_path_tokenizer_top
// Streaming JSONPath tokenizer: one UTF-16 code unit in, key units, segment
// ends, index and wildcard items, and one verdict per expression out.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------
//   item     | item_valid / item_ready     | item_t (code unit, end mark)
//   result   | result_valid / result_ready | result_t
//
// One code unit per cycle while item_ready is high; the parse state updates
// in the cycle of the transaction and its results enter the result queue at
// the same edge. An item producing two results (a final unit that also
// emits, plus the verdict) needs two output transactions to drain.
// item_ready drops only when the four-entry result queue lacks room for two.
// Reset returns the parser to expecting '$' and empties the queue.
// ----------------------------------------------------------------------------
module json_path_tokenizer_top
  import jpt_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  wire     result_ready,
  output result_t result
);

  push_t push;
  logic  accept;

  assign accept = item_valid && item_ready;

  jpt_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .push   (push)
  );

  jpt_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .space        (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
